[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the RTL; both sample on clk and sit out reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

[hw/rtl/rot90_pkg.sv]
package rot90_pkg;

  localparam int MAX_DIM    = 64;
  localparam int MAX_PIXELS = 4096;

  localparam int DIM_W   = $clog2(MAX_DIM);
  localparam int EFF_W   = DIM_W + 1;
  localparam int TOT_W   = 2 * EFF_W;
  localparam int ADDR_W  = $clog2(MAX_PIXELS);
  localparam int PROD_W  = DIM_W + EFF_W;
  localparam int REG_W   = 7;
  localparam int PIX_W   = 8;
  localparam int CNT_W   = 13;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [REG_W-1:0] DIM_RESET = REG_W'(64);

  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  typedef enum logic [0:0] {
    OP_LOAD  = 1'b0,
    OP_FETCH = 1'b1
  } opcode_t;

  // Effective dimension: zero acts as one, oversize clamps to MAX_DIM.
  function automatic logic [EFF_W-1:0] eff_dim(input logic [REG_W-1:0] v);
    logic [EFF_W-1:0] res;
    if (v == '0) begin
      res = EFF_W'(1);
    end else if (int'(v) > MAX_DIM) begin
      res = EFF_W'(MAX_DIM);
    end else begin
      res = EFF_W'(v);
    end
    return res;
  endfunction

  typedef struct packed {
    logic [EFF_W-1:0] width;
    logic [EFF_W-1:0] height;
    logic             restart;
    logic [DIM_W-1:0] restart_row;
  } cfg_t;

  typedef struct packed {
    logic              fetch;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [PIX_W-1:0]  wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              last;
    logic [CNT_W-1:0]  count;
    logic              status;
  } req_t;

endpackage

[hw/rtl/rot90_regs.sv]
module rot90_regs
  import rot90_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic [REG_W-1:0] width_r, width_nxt;
  logic [REG_W-1:0] height_r, height_nxt;
  logic             wr;
  reg_idx_t         idx;
  logic [EFF_W-1:0] h_new_eff;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[2]);

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    prdata     = '0;
    case (idx)
      REG_WIDTH: begin
        if (wr) width_nxt = pwdata[REG_W-1:0];
        prdata = PDATA_W'(width_r);
      end
      REG_HEIGHT: begin
        if (wr) height_nxt = pwdata[REG_W-1:0];
        prdata = PDATA_W'(height_r);
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_RESET;
      height_r <= DIM_RESET;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  // A write to either register restarts the image; start row follows the new height
  assign h_new_eff       = eff_dim(height_nxt);
  assign cfg.width       = eff_dim(width_r);
  assign cfg.height      = eff_dim(height_r);
  assign cfg.restart     = wr;
  assign cfg.restart_row = DIM_W'(h_new_eff - EFF_W'(1));

endmodule

[hw/rtl/rot90_ctrl.sv]
`include "assert_macros.svh"

module rot90_ctrl
  import rot90_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic             opcode,
  input  logic [PIX_W-1:0] pixel,
  output req_t             req
);

  logic [TOT_W-1:0]  load_idx_r, load_idx_nxt;
  logic [DIM_W-1:0]  col_r, col_nxt;
  logic [DIM_W-1:0]  row_r, row_nxt;
  logic [CNT_W-1:0]  zcnt_r, zcnt_nxt;
  logic              loaded_r, loaded_nxt;

  logic              accept;
  logic              is_load;
  logic              is_fetch;
  logic [DIM_W-1:0]  w_m1;
  logic [DIM_W-1:0]  h_m1;
  logic [TOT_W-1:0]  total;
  logic [TOT_W-1:0]  idx_inc;
  logic [PROD_W-1:0] row_base;
  logic [PROD_W-1:0] addr_sum;
  logic              is_last;

  assign accept   = in_valid & in_ready;
  assign is_load  = accept & (opcode == OP_LOAD);
  assign is_fetch = accept & (opcode == OP_FETCH);

  assign w_m1     = DIM_W'(cfg.width - EFF_W'(1));
  assign h_m1     = DIM_W'(cfg.height - EFF_W'(1));
  assign total    = TOT_W'(cfg.width) * TOT_W'(cfg.height);
  assign idx_inc  = load_idx_r + TOT_W'(1);
  // Source address of the rotated pixel: row * width + column
  assign row_base = PROD_W'(row_r) * PROD_W'(cfg.width);
  assign addr_sum = row_base + PROD_W'(col_r);
  assign is_last  = (col_r >= w_m1) && (row_r == '0);

  always_comb begin
    load_idx_nxt = load_idx_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    zcnt_nxt     = zcnt_r;
    loaded_nxt   = loaded_r;
    if (cfg.restart) begin
      load_idx_nxt = '0;
      col_nxt      = '0;
      row_nxt      = cfg.restart_row;
      zcnt_nxt     = '0;
      loaded_nxt   = 1'b0;
    end else if (is_load) begin
      if (!loaded_r) begin
        load_idx_nxt = idx_inc;
        zcnt_nxt     = zcnt_r + CNT_W'(pixel == '0);
        if (idx_inc >= total) loaded_nxt = 1'b1;
      end
    end else if (is_fetch && loaded_r) begin
      if (is_last) begin
        load_idx_nxt = '0;
        col_nxt      = '0;
        row_nxt      = h_m1;
        zcnt_nxt     = '0;
        loaded_nxt   = 1'b0;
      end else if (row_r == '0) begin
        row_nxt = h_m1;
        col_nxt = col_r + DIM_W'(1);
      end else begin
        row_nxt = row_r - DIM_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_idx_r <= '0;
      col_r      <= '0;
      row_r      <= DIM_W'(MAX_DIM - 1);
      zcnt_r     <= '0;
      loaded_r   <= 1'b0;
    end else begin
      load_idx_r <= load_idx_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      zcnt_r     <= zcnt_nxt;
      loaded_r   <= loaded_nxt;
    end
  end

  always_comb begin
    req.fetch   = is_fetch;
    req.wr_en   = is_load & ~loaded_r & ~cfg.restart;
    req.wr_addr = ADDR_W'(load_idx_r);
    req.wr_data = pixel;
    req.rd_en   = is_fetch & loaded_r;
    req.rd_addr = ADDR_W'(addr_sum);
    req.last    = loaded_r & is_last;
    req.count   = loaded_r ? zcnt_r : '0;
    req.status  = ~loaded_r;
  end

  `ASSERT_IMPL(a_loaded_full, loaded_r, load_idx_r == total,
    "image marked loaded with load index off the pixel total")
  `ASSERT_IMPL(a_idle_scan_pos, !loaded_r, (row_r == h_m1) && (col_r == '0),
    "scan position moved while no full image is held")
  `ASSERT_CLK(a_scan_in_range, (row_r <= h_m1) && (col_r <= w_m1),
    "scan position outside the configured image")

endmodule

[hw/rtl/rot90_out.sv]
`include "assert_macros.svh"

module rot90_out
  import rot90_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  req_t             req,
  input  logic             out_ready,
  output logic             in_ready,
  output logic             out_valid,
  output logic [PIX_W-1:0] pixel_out,
  output logic             last_pixel,
  output logic [CNT_W-1:0] count,
  output logic             status
);

  logic [PIX_W-1:0] mem [MAX_PIXELS];
  logic [PIX_W-1:0] rd_r;
  logic             valid_r, valid_nxt;
  logic             last_r;
  logic [CNT_W-1:0] count_r;
  logic             status_r;

  // Result register doubles as the memory's read register; it only loads on a new fetch
  assign in_ready = ~valid_r | out_ready;

  always_ff @(posedge clk) begin
    if (req.wr_en) mem[req.wr_addr] <= req.wr_data;
    if (req.rd_en) rd_r <= mem[req.rd_addr];
  end

  always_comb begin
    valid_nxt = valid_r;
    if (req.fetch) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.fetch) begin
      last_r   <= req.last;
      count_r  <= req.count;
      status_r <= req.status;
    end
  end

  assign out_valid  = valid_r;
  assign pixel_out  = status_r ? '0 : rd_r;
  assign last_pixel = last_r;
  assign count      = count_r;
  assign status     = status_r;

  `ASSERT_IMPL(a_not_ready_clean, valid_r && status_r, !last_r && (count_r == '0),
    "not-ready beat carries a last mark or a count")
  `ASSERT_CLK(a_fetch_slot_free, !(req.fetch && valid_r && !out_ready),
    "fetch accepted over a result still waiting")

endmodule

[hw/rtl/image_rotate_90_with_transparency_count_unit.sv]
// 90-degree rotator for an 8-bit indexed image, with a count of zero pixels.
// Configure image_width (byte address 0) and image_height (byte address 4) over
// the APB port while idle; any write discards the image in progress.
// Input beats: opcode 0 stores the next source pixel in row-major order and gives
// no result; opcode 1 fetches the next rotated pixel (column 0 first, each column
// from the bottom row up) with last_pixel on the final one and the zero count.
// A fetch before the image is fully loaded returns status 1 with zero fields.
// Loads arriving after a full image and before its final fetch are dropped.
// A fetch result is valid in the cycle after acceptance, taken from the
// registered read of the 4096 x 8 frame memory. Throughput is one beat per
// cycle while in_ready is high, loads and fetches alike: at most one memory
// access per beat. in_ready drops only while a result waits and out_ready is
// low; the result then holds until taken.
// Reset: dimensions return to 64 x 64, the memory keeps its contents but the
// block restarts empty, so no stale pixel is ever read. No clearing pass.
module image_rotate_90_with_transparency_count_unit
  import rot90_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_opcode,
  input  logic [PIX_W-1:0]   in_pixel_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [PIX_W-1:0]   out_pixel_out,
  output logic               out_last_pixel,
  output logic [CNT_W-1:0]   out_transparent_count,
  output logic               out_status
);

  cfg_t cfg;
  req_t req;

  rot90_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rot90_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .opcode   (in_opcode),
    .pixel    (in_pixel_in),
    .req      (req)
  );

  rot90_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req),
    .out_ready  (out_ready),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .pixel_out  (out_pixel_out),
    .last_pixel (out_last_pixel),
    .count      (out_transparent_count),
    .status     (out_status)
  );

endmodule
